[rtl/msp_pkg.sv]
// Package for the motor speed panel: command codes, display patterns and
// the small arithmetic helpers used by the datapath.
// Depends on nothing; imported by motor_speed_panel.
package msp_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CsrInputMode  = 2'd0;
   localparam logic [1:0] CsrSpeedStep  = 2'd1;
   localparam logic [1:0] CsrBlankTicks = 2'd2;

   // Command bytes, serial characters and masked switch pin patterns.
   localparam logic [7:0] CodeIncPin   = 8'h32;
   localparam logic [7:0] CodeDecPin   = 8'h31;
   localparam logic [7:0] CodeInvPin   = 8'h23;
   localparam logic [7:0] CodeStopPin  = 8'h13;
   localparam logic [7:0] CodeIncChar  = 8'h2B;
   localparam logic [7:0] CodeDecChar  = 8'h2D;
   localparam logic [7:0] CodeInvLow   = 8'h69;
   localparam logic [7:0] CodeInvUp    = 8'h49;
   localparam logic [7:0] CodeStopLow  = 8'h70;
   localparam logic [7:0] CodeStopUp   = 8'h50;
   localparam logic [7:0] PinMask      = 8'h33;

   localparam logic [6:0] SpeedMax     = 7'd100;
   localparam logic [7:0] SegBlank     = 8'hFF;
   localparam logic [7:0] SegMinus     = 8'hBF;

   // Digit enables driven for each display position.
   localparam logic [1:0] SelUnits     = 2'd3;
   localparam logic [1:0] SelTens      = 2'd2;
   localparam logic [1:0] SelSign      = 2'd1;

   typedef enum logic [2:0] {
      CMD_NONE = 3'd0,
      CMD_INC  = 3'd1,
      CMD_DEC  = 3'd2,
      CMD_INV  = 3'd3,
      CMD_STOP = 3'd4
   } cmd_type;

   function automatic cmd_type decode_cmd(input logic [7:0] code);
      cmd_type cmd;
      case (code) inside
         CodeIncPin, CodeIncChar:             cmd = CMD_INC;
         CodeDecPin, CodeDecChar:             cmd = CMD_DEC;
         CodeInvPin, CodeInvLow, CodeInvUp:   cmd = CMD_INV;
         CodeStopPin, CodeStopLow, CodeStopUp: cmd = CMD_STOP;
         default:                             cmd = CMD_NONE;
      endcase
      return cmd;
   endfunction

   // speed*255/100 as speed*(255*5243) >> 19; exact for speeds up to 100.
   function automatic logic [7:0] duty_of_speed(input logic [6:0] speed);
      logic [27:0] prod;
      prod = 28'(speed) * 28'd1336965;
      return prod[26:19];
   endfunction

   // Tens digit as speed*205 >> 11; exact for speeds up to 100.
   function automatic logic [3:0] tens_of(input logic [6:0] speed);
      logic [17:0] prod;
      prod = 18'(speed) * 18'd205;
      return prod[14:11];
   endfunction

   function automatic logic [7:0] seg_of_digit(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SegBlank;
      endcase
      return seg;
   endfunction

endpackage

[rtl/motor_speed_panel.sv]
// Motor speed panel top level: command decode, speed and duty control,
// direction inversion with display blanking, seven segment multiplexing.
// Depends on msp_pkg.
//
// Usage. The req_ channel carries one transaction per command poll
// (req_func = 0, req_command_code holds the character or raw pin byte) or
// per 5 ms tick (req_func = 1). Every request transaction yields exactly one
// rsp_ transaction with the duty, direction pins, segment pattern, digit
// enables and speed as they stand after that request.
// The csr_ channel writes input_mode (index 0), speed_step (index 1) and
// blank_ticks (index 2); it is always ready, and writes to index 3 are
// dropped. Registers should only be written while no request is in flight.
//
// Timing. A request is captured in an input register at acceptance and is
// processed once the response slot is free or being emptied, when the panel
// state registers take their new values; those state registers double as
// the response register. Throughput is one transaction per cycle as long
// as rsp_ready stays high.
// When the receiver stalls, the response and the state hold, the input
// register keeps one waiting request, and req_ready drops once it is full.
// Reset restores speed 50, duty 128, direction zero, display blank with
// enables 3, and the configuration defaults (mode 0, step 5, 100 ticks).
module motor_speed_panel
   import msp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_command_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_pwm_compare,
   output logic       rsp_dir_a,
   output logic       rsp_dir_b,
   output logic [7:0] rsp_segments,
   output logic [1:0] rsp_digit_select,
   output logic [6:0] rsp_speed,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data
);

   // Configuration registers.
   logic       mode_ff;
   logic [5:0] step_ff;
   logic [6:0] blank_ticks_ff;

   // Input register.
   logic       in_valid_ff;
   logic       in_func_ff;
   logic [7:0] in_code_ff;

   // Panel state, which is also the response payload.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] speed_ff, speed_in;
   logic       stopped_ff, stopped_in;
   logic       latch_ff, latch_in;
   logic       dir_ff, dir_in;
   logic [6:0] blank_ff, blank_in;
   logic [1:0] digit_ff, digit_in;
   logic [7:0] duty_ff, duty_in;
   logic [7:0] seg_ff, seg_in;
   logic [1:0] sel_ff, sel_in;

   logic       fire;
   cmd_type    cmd;
   logic [7:0] code_eff;
   logic [7:0] speed_sum;
   logic [3:0] tens_raw, tens, units;
   logic [6:0] tens_x10;

   // A request is processed when the response slot is free or being emptied.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         step_ff        <= 6'd5;
         blank_ticks_ff <= 7'd100;
      end else if (csr_valid) begin
         case (csr_index)
            CsrInputMode:  mode_ff        <= csr_data[0];
            CsrSpeedStep:  step_ff        <= csr_data[5:0];
            CsrBlankTicks: blank_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_code_ff <= req_command_code;
      end
   end

   // Switch pins are masked before decoding; serial characters are not.
   assign code_eff  = mode_ff ? (in_code_ff & PinMask) : in_code_ff;
   assign cmd       = decode_cmd(code_eff);
   assign speed_sum = 8'(speed_ff) + 8'(step_ff);

   // Display digits; a speed of 100 shows as 99.
   assign tens_raw  = tens_of(speed_ff);
   assign tens_x10  = 7'(tens_raw) * 7'd10;
   assign tens      = (tens_raw >= 4'd10) ? 4'd9 : tens_raw;
   assign units     = (tens_raw >= 4'd10) ? 4'd9 : 4'(speed_ff - tens_x10);

   always_comb begin
      speed_in   = speed_ff;
      stopped_in = stopped_ff;
      latch_in   = latch_ff;
      dir_in     = dir_ff;
      blank_in   = blank_ff;
      digit_in   = digit_ff;
      duty_in    = duty_ff;
      seg_in     = seg_ff;
      sel_in     = sel_ff;

      if (fire && in_func_ff) begin
         if (blank_ff != 7'd0) begin
            // Inversion pending: count down with the display blanked.
            blank_in = blank_ff - 7'd1;
            seg_in   = SegBlank;
            if (blank_ff == 7'd1) begin
               dir_in  = !dir_ff;
               duty_in = duty_of_speed(speed_ff);
            end
         end else begin
            case (digit_ff)
               2'd0: begin
                  sel_in = SelUnits;
                  seg_in = seg_of_digit(units);
               end
               2'd1: begin
                  sel_in = SelTens;
                  seg_in = seg_of_digit(tens);
               end
               2'd2: begin
                  sel_in = SelSign;
                  seg_in = dir_ff ? SegMinus : SegBlank;
               end
               default: ;
            endcase
            digit_in = (digit_ff >= 2'd2) ? 2'd0 : digit_ff + 2'd1;
         end
      end else if (fire && blank_ff == 7'd0) begin
         // Command poll; ignored entirely while an inversion is pending.
         case (cmd)
            CMD_INC: begin
               if (!latch_ff) begin
                  latch_in = 1'b1;
                  if (stopped_ff) begin
                     stopped_in = 1'b0;
                     duty_in    = duty_of_speed(speed_ff);
                  end else if (speed_ff < SpeedMax) begin
                     speed_in = (speed_sum > 8'(SpeedMax)) ? SpeedMax : speed_sum[6:0];
                     duty_in  = duty_of_speed(speed_in);
                  end
               end
            end
            CMD_DEC: begin
               if (!latch_ff) begin
                  latch_in = 1'b1;
                  if (stopped_ff) begin
                     stopped_in = 1'b0;
                     duty_in    = duty_of_speed(speed_ff);
                  end else if (speed_ff != 7'd0) begin
                     speed_in = (speed_ff >= 7'(step_ff)) ? speed_ff - 7'(step_ff) : 7'd0;
                     duty_in  = duty_of_speed(speed_in);
                  end
               end
            end
            CMD_INV: begin
               if (!latch_ff && !stopped_ff) begin
                  latch_in = 1'b1;
                  duty_in  = 8'd0;
                  blank_in = blank_ticks_ff;
                  if (blank_ticks_ff == 7'd0) begin
                     dir_in  = !dir_ff;
                     duty_in = duty_of_speed(speed_ff);
                  end
               end
            end
            CMD_STOP: begin
               if (!latch_ff) begin
                  latch_in   = 1'b1;
                  stopped_in = 1'b1;
                  duty_in    = 8'd0;
               end
            end
            default: latch_in = 1'b0;
         endcase
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         speed_ff     <= 7'd50;
         stopped_ff   <= 1'b0;
         latch_ff     <= 1'b0;
         dir_ff       <= 1'b0;
         blank_ff     <= 7'd0;
         digit_ff     <= 2'd1;
         duty_ff      <= 8'd128;
         seg_ff       <= SegBlank;
         sel_ff       <= SelUnits;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         speed_ff     <= speed_in;
         stopped_ff   <= stopped_in;
         latch_ff     <= latch_in;
         dir_ff       <= dir_in;
         blank_ff     <= blank_in;
         digit_ff     <= digit_in;
         duty_ff      <= duty_in;
         seg_ff       <= seg_in;
         sel_ff       <= sel_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pwm_compare  = duty_ff;
   assign rsp_dir_a        = dir_ff;
   assign rsp_dir_b        = !dir_ff;
   assign rsp_segments     = seg_ff;
   assign rsp_digit_select = sel_ff;
   assign rsp_speed        = speed_ff;

   // The speed setting never leaves its 0..100 range.
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      speed_ff <= SpeedMax)
      else $error("speed setting above 100");

   // The motor is held off for as long as an inversion is pending.
   a_blank_duty: assert property (@(posedge clock) disable iff (reset)
      blank_ff != 7'd0 |-> duty_ff == 8'd0)
      else $error("nonzero duty during inversion");

   // A stopped motor always has a zero compare value.
   a_stop_duty: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> duty_ff == 8'd0)
      else $error("nonzero duty while stopped");

   // A stalled response does not change under the receiver.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(speed_ff) && $stable(duty_ff) && $stable(seg_ff))
      else $error("response changed while stalled");

endmodule

[test/tb_motor_speed_panel.sv]
// Self-checking testbench for motor_speed_panel: drives polls, ticks and
// register writes, and checks every response against its own panel model.
// Depends on msp_pkg and the motor_speed_panel RTL.
module tb_motor_speed_panel
   import msp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // A byte that decodes to no command in either input mode.
   localparam logic [7:0] CodeRelease = 8'h00;
   // Cycles without any accepted transaction before the run is abandoned.
   localparam int QuietLimit = 4000;

   // One response transaction, as the block reports the panel after a request.
   typedef struct packed {
      logic [7:0] pwm_compare;
      logic       dir_a;
      logic       dir_b;
      logic [7:0] segments;
      logic [1:0] digit_select;
      logic [6:0] speed;
   } panel_status_type;

   // Panel model plus the queue of panel states still owed by the block.
   // apply_request advances the model for an accepted request and queues the
   // resulting panel state; check_status pops the oldest one and compares.
   class panel_board_type;
      logic       mode;
      logic [5:0] step_size;
      logic [6:0] blank_len;
      logic [6:0] speed_lvl;
      logic       halted;
      logic       latched;
      logic       dir;
      logic [6:0] blank_left;
      logic [1:0] digit;
      logic [7:0] duty;
      logic [7:0] seg;
      logic [1:0] sel;
      logic [7:0] digit_seg[10];
      panel_status_type status_due[$];
      int errors;

      function new();
         digit_seg  = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
         mode       = 1'b0;
         step_size  = 6'd5;
         blank_len  = 7'd100;
         speed_lvl  = 7'd50;
         halted     = 1'b0;
         latched    = 1'b0;
         dir        = 1'b0;
         blank_left = 7'd0;
         digit      = 2'd1;
         duty       = 8'd128;
         seg        = SegBlank;
         sel        = SelUnits;
         errors     = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [6:0] data);
         case (index)
            CsrInputMode:  mode      = data[0];
            CsrSpeedStep:  step_size = data[5:0];
            CsrBlankTicks: blank_len = data;
            default: ;
         endcase
      endfunction

      function cmd_type classify(logic [7:0] code);
         if (code == CodeIncChar || code == CodeIncPin)
            return CMD_INC;
         if (code == CodeDecChar || code == CodeDecPin)
            return CMD_DEC;
         if (code == CodeInvLow || code == CodeInvUp || code == CodeInvPin)
            return CMD_INV;
         if (code == CodeStopLow || code == CodeStopUp || code == CodeStopPin)
            return CMD_STOP;
         return CMD_NONE;
      endfunction

      function logic [7:0] speed_duty();
         int unsigned scaled;
         scaled = (int'(speed_lvl) * 255) / 100;
         return 8'(scaled);
      endfunction

      function void end_inversion();
         dir  = ~dir;
         duty = speed_duty();
      endfunction

      function void poll(logic [7:0] code);
         int level;
         if (blank_left != 7'd0)
            return;
         if (mode)
            code = code & PinMask;
         case (classify(code))
            CMD_INC: begin
               if (!latched) begin
                  latched = 1'b1;
                  if (halted) begin
                     halted = 1'b0;
                     duty   = speed_duty();
                  end else if (speed_lvl < SpeedMax) begin
                     level = int'(speed_lvl) + int'(step_size);
                     if (level > int'(SpeedMax))
                        level = int'(SpeedMax);
                     speed_lvl = 7'(level);
                     duty      = speed_duty();
                  end
               end
            end
            CMD_DEC: begin
               if (!latched) begin
                  latched = 1'b1;
                  if (halted) begin
                     halted = 1'b0;
                     duty   = speed_duty();
                  end else if (speed_lvl != 7'd0) begin
                     level = int'(speed_lvl) - int'(step_size);
                     if (level < 0)
                        level = 0;
                     speed_lvl = 7'(level);
                     duty      = speed_duty();
                  end
               end
            end
            CMD_INV: begin
               if (!latched && !halted) begin
                  latched    = 1'b1;
                  duty       = 8'd0;
                  blank_left = blank_len;
                  if (blank_left == 7'd0)
                     end_inversion();
               end
            end
            CMD_STOP: begin
               if (!latched) begin
                  latched = 1'b1;
                  halted  = 1'b1;
                  duty    = 8'd0;
               end
            end
            default: latched = 1'b0;
         endcase
      endfunction

      function void tick();
         int units;
         int tens;
         if (blank_left != 7'd0) begin
            blank_left = blank_left - 7'd1;
            seg        = SegBlank;
            if (blank_left == 7'd0)
               end_inversion();
            return;
         end
         units = int'(speed_lvl) % 10;
         tens  = int'(speed_lvl) / 10;
         if (tens >= 10) begin
            tens  = 9;
            units = 9;
         end
         case (digit)
            2'd0: begin
               sel = SelUnits;
               seg = digit_seg[units];
            end
            2'd1: begin
               sel = SelTens;
               seg = digit_seg[tens];
            end
            2'd2: begin
               sel = SelSign;
               seg = dir ? SegMinus : SegBlank;
            end
            default: ;
         endcase
         digit = (digit >= 2'd2) ? 2'd0 : digit + 2'd1;
      endfunction

      function void apply_request(logic func, logic [7:0] code);
         panel_status_type due;
         if (func)
            tick();
         else
            poll(code);
         due.pwm_compare  = duty;
         due.dir_a        = dir;
         due.dir_b        = ~dir;
         due.segments     = seg;
         due.digit_select = sel;
         due.speed        = speed_lvl;
         status_due.push_back(due);
      endfunction

      function void check_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_status(panel_status_type got);
         panel_status_type want;
         if (status_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = status_due.pop_front();
         check_field("pwm_compare", want.pwm_compare, got.pwm_compare);
         check_field("dir_a", want.dir_a, got.dir_a);
         check_field("dir_b", want.dir_b, got.dir_b);
         check_field("segments", want.segments, got.segments);
         check_field("digit_select", want.digit_select, got.digit_select);
         check_field("speed", want.speed, got.speed);
      endfunction

      function int pending();
         return status_due.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_func = 1'b0;
   logic [7:0] req_command_code = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_pwm_compare;
   logic       rsp_dir_a;
   logic       rsp_dir_b;
   logic [7:0] rsp_segments;
   logic [1:0] rsp_digit_select;
   logic [6:0] rsp_speed;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CsrInputMode;
   logic [6:0] csr_data = 7'd0;

   panel_board_type board = new();

   // Sender burst bookkeeping: requests left in the current burst.
   int burst_left = 0;

   motor_speed_panel i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_command_code (req_command_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pwm_compare  (rsp_pwm_compare),
      .rsp_dir_a        (rsp_dir_a),
      .rsp_dir_b        (rsp_dir_b),
      .rsp_segments     (rsp_segments),
      .rsp_digit_select (rsp_digit_select),
      .rsp_speed        (rsp_speed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Response side. DUT outputs read right after the edge still hold their
   // pre-edge values, so a transaction is seen exactly when the DUT sees it.
   // The ready pattern is redrawn at the start of each window: about a third
   // of the windows never stall, the rest stall on a random 16-bit pattern.
   logic [15:0] ready_pattern = 16'hFFFF;
   int          ready_pos = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_status({rsp_pwm_compare, rsp_dir_a, rsp_dir_b, rsp_segments,
                             rsp_digit_select, rsp_speed});
      if (ready_pos % 64 == 0)
         ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      rsp_ready <= ready_pattern[ready_pos % 16];
      ready_pos++;
   end

   // Watchdog: any accepted transaction on any channel counts as progress.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Sends one request transaction. Between bursts the sender drops valid
   // for a random gap; a burst is sometimes long enough to cover a stretch
   // with no sender idling at all. Valid stays high across back-to-back
   // requests of a burst, so it is assigned only once per edge.
   task automatic send_item(input logic func, input logic [7:0] code);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 24);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_command_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.apply_request(func, code);
      burst_left--;
   endtask

   // Stops sending and waits until every queued response has been checked.
   // Every request yields a response, so the DUT is idle afterwards.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Writes all three registers while the DUT is idle. The csr valid stays
   // high across the three writes and is lowered once at the end.
   task automatic configure(input logic mode, input logic [5:0] step_size,
                            input logic [6:0] blank_len);
      logic [1:0] index[3];
      logic [6:0] value[3];
      index = '{CsrInputMode, CsrSpeedStep, CsrBlankTicks};
      value = '{{6'd0, mode}, {1'b0, step_size}, blank_len};
      drain();
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= index[k];
         csr_data  <= value[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         board.write_reg(index[k], value[k]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] serial_codes[10];
      logic [7:0] pin_codes[4];
      logic       mode;
      logic [5:0] step_size;
      logic [6:0] blank_len;
      logic [7:0] code;
      int         tick_pct;
      int         count;
      int         pick;

      serial_codes = '{CodeIncChar, CodeIncPin, CodeDecChar, CodeDecPin, CodeInvLow,
                       CodeInvUp, CodeInvPin, CodeStopLow, CodeStopUp, CodeStopPin};
      pin_codes    = '{CodeIncPin, CodeDecPin, CodeInvPin, CodeStopPin};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset configuration: the digit multiplexing
      // from its reset index, one action per press, release of the latch,
      // stop with a latched invert and an invert while stopped, then resume.
      repeat (4) send_item(1'b1, 8'h00);
      send_item(1'b0, CodeIncChar);
      send_item(1'b0, CodeIncChar);
      send_item(1'b0, CodeRelease);
      send_item(1'b0, CodeDecChar);
      send_item(1'b0, CodeRelease);
      send_item(1'b0, CodeStopLow);
      send_item(1'b0, CodeInvLow);
      send_item(1'b0, CodeRelease);
      send_item(1'b0, CodeInvUp);
      send_item(1'b0, CodeIncChar);
      send_item(1'b0, CodeRelease);

      // Largest step with no blanking: saturation at full speed, the full
      // speed display, an inversion that completes inside the poll and the
      // sign digit, then the walk down to zero speed and a decrease there.
      configure(1'b0, 6'd50, 7'd0);
      send_item(1'b0, CodeIncPin);
      send_item(1'b0, CodeRelease);
      send_item(1'b0, CodeIncChar);
      send_item(1'b0, CodeRelease);
      send_item(1'b0, CodeInvPin);
      repeat (3) send_item(1'b1, 8'hFF);
      send_item(1'b0, CodeRelease);
      send_item(1'b0, CodeDecPin);
      send_item(1'b0, CodeRelease);
      send_item(1'b0, CodeDecChar);
      send_item(1'b0, CodeRelease);
      send_item(1'b0, CodeDecChar);
      send_item(1'b0, CodeStopUp);

      // Random phases. The first two carry the register extremes; the phase
      // with the longest blanking is tick heavy so inversions still finish.
      for (int phase = 0; phase < 8; phase++) begin
         mode      = phase[0];
         step_size = 6'($urandom_range(1, 50));
         blank_len = 7'($urandom_range(1, 10));
         tick_pct  = 40;
         count     = 130;
         case (phase)
            0: begin
               mode      = 1'b1;
               step_size = 6'd1;
               blank_len = 7'd1;
            end
            1: begin
               mode      = 1'b0;
               step_size = 6'd50;
               blank_len = 7'd127;
               tick_pct  = 75;
               count     = 200;
            end
            2: step_size = 6'd50;
            3: step_size = 6'd1;
            default: ;
         endcase
         configure(mode, step_size, blank_len);
         repeat (count) begin
            if ($urandom_range(0, 99) < tick_pct) begin
               // The code byte is a don't-care on ticks; keep it random.
               send_item(1'b1, 8'($urandom));
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 55) begin
                  // Switch pins carry random levels on the masked-off bits.
                  code = mode ? (pin_codes[$urandom_range(0, 3)] | (8'($urandom) & ~PinMask))
                              : serial_codes[$urandom_range(0, 9)];
               end else if (pick < 85) begin
                  code = mode ? (8'($urandom) & ~PinMask) : CodeRelease;
               end else begin
                  code = 8'($urandom);
               end
               send_item(1'b0, code);
            end
         end
      end

      // All requests are in; wait out the outstanding responses, then keep
      // clocking idle to catch any spurious response.
      drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
rtl/msp_pkg.sv
rtl/motor_speed_panel.sv
test/tb_motor_speed_panel.sv
